// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SLQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/slq_pkg.sv -----
// Package for the sorted list queue: sizes, action codes and beat types.
package slq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [1:0] ACT_INSERT  = 2'd0;
	localparam logic [1:0] ACT_POP     = 2'd1;
	localparam logic [1:0] ACT_REVERSE = 2'd2;
	localparam logic [1:0] ACT_CLEAR   = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] value;
	} slq_cmd_t;

	typedef struct packed {
		logic               ok;
		logic signed [31:0] head_value;
	} slq_result_t;

endpackage

// ----- design/sorted_list_queue_top.sv -----
// Sorted list queue: a command is taken when start is high and busy is low, and its
// result is shown for one cycle with done high; the receiver cannot stall it. An insert
// or a pop keeps busy high while every stored value passes through the store, and a
// reverse while the values are swapped in pairs. The store has one registered read and
// one write a cycle, and there is one signed comparator. Clear, an insert
// on a full store, a pop on an empty store and a reverse of fewer than two values finish
// at once: done is high in the cycle after the command. A new command may be given in
// the cycle done is up.
module sorted_list_queue_top import slq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  slq_cmd_t    cmd,
	output logic        done,
	output slq_result_t result
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_INS_RD = 4'd1;
	localparam logic [3:0] ST_INS_EV = 4'd2;
	localparam logic [3:0] ST_POP_RD = 4'd3;
	localparam logic [3:0] ST_POP_EV = 4'd4;
	localparam logic [3:0] ST_REV_RL = 4'd5;
	localparam logic [3:0] ST_REV_RH = 4'd6;
	localparam logic [3:0] ST_REV_WL = 4'd7;
	localparam logic [3:0] ST_REV_WH = 4'd8;

	logic [3:0]         state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   k_q;
	logic [IDX_W-1:0]   hi_q;
	logic signed [31:0] carry_q;
	logic               placing_q;
	logic               done_q;
	logic               ok_q;
	logic signed [31:0] head_q;

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rdata_q;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [IDX_W-1:0]   mem_raddr;
	logic signed [31:0] mem_wdata;

	logic               less;
	logic [CNT_W-1:0]   k_dec;

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = '{ok: ok_q, head_value: head_q};

	// shared comparator: stored value below the value being placed
	assign less  = $signed(rdata_q) < $signed(carry_q);
	assign k_dec = k_q - 1'b1;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = k_q[IDX_W-1:0];
		mem_raddr = k_q[IDX_W-1:0];
		mem_wdata = carry_q;
		case (state_q)
			ST_INS_RD: begin
				mem_we = (k_q == count_q);
			end
			ST_INS_EV: begin
				mem_we = placing_q || !less;
			end
			ST_POP_EV: begin
				mem_we    = (k_q != '0);
				mem_waddr = k_dec[IDX_W-1:0];
				mem_wdata = rdata_q;
			end
			ST_REV_RH: begin
				mem_raddr = hi_q;
			end
			ST_REV_WL: begin
				mem_we    = 1'b1;
				mem_wdata = rdata_q;
			end
			ST_REV_WH: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			k_q       <= '0;
			hi_q      <= '0;
			placing_q <= 1'b0;
			done_q    <= 1'b0;
			ok_q      <= 1'b0;
			head_q    <= '0;
			carry_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						k_q       <= '0;
						placing_q <= 1'b0;
						carry_q   <= cmd.value;
						hi_q      <= IDX_W'(count_q - 1'b1);
						head_q    <= '0;
						ok_q      <= 1'b1;
						case (cmd.action)
							ACT_INSERT: begin
								if (count_q == CNT_W'(DEPTH)) begin
									ok_q   <= 1'b0;
									done_q <= 1'b1;
								end else begin
									state_q <= ST_INS_RD;
								end
							end
							ACT_POP: begin
								if (count_q == '0) begin
									ok_q   <= 1'b0;
									done_q <= 1'b1;
								end else begin
									state_q <= ST_POP_RD;
								end
							end
							ACT_REVERSE: begin
								if (count_q < CNT_W'(2)) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_REV_RL;
								end
							end
							default: begin
								count_q <= '0;
								done_q  <= 1'b1;
							end
						endcase
					end
				end
				ST_INS_RD: begin
					if (k_q == count_q) begin
						count_q <= count_q + 1'b1;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_INS_EV;
					end
				end
				ST_INS_EV: begin
					if (placing_q || !less) begin
						carry_q   <= rdata_q;
						placing_q <= 1'b1;
					end
					k_q     <= k_q + 1'b1;
					state_q <= ST_INS_RD;
				end
				ST_POP_RD: begin
					if (k_q == count_q) begin
						count_q <= count_q - 1'b1;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_POP_EV;
					end
				end
				ST_POP_EV: begin
					if (k_q == '0)
						head_q <= rdata_q;
					k_q     <= k_q + 1'b1;
					state_q <= ST_POP_RD;
				end
				ST_REV_RL: begin
					if (k_q >= CNT_W'(hi_q)) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_REV_RH;
					end
				end
				ST_REV_RH: begin
					carry_q <= rdata_q;
					state_q <= ST_REV_WL;
				end
				ST_REV_WL: begin
					state_q <= ST_REV_WH;
				end
				ST_REV_WH: begin
					k_q     <= k_q + 1'b1;
					hi_q    <= hi_q - 1'b1;
					state_q <= ST_REV_RL;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- design/slq_checker.sv -----
// Port checker for the sorted list queue, bound to the top level.
`include "assert_macros.svh"

module slq_checker import slq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input slq_cmd_t    cmd,
	input logic        done,
	input slq_result_t result
);

	logic unused_cmd;
	assign unused_cmd = ^cmd;

	`SLQ_ASSERT_NEXT(a_accept_progress, clk, arst_n, start && !busy, busy || done, "accepted command neither busy nor done")
	`SLQ_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy, "result beat while busy")
	`SLQ_ASSERT_NOW(a_fail_zero, clk, arst_n, done && !result.ok, result.head_value == 32'sd0, "failed beat with nonzero head value")
	`SLQ_ASSERT_NOW(a_end_done, clk, arst_n, $fell(busy), done, "busy fell without a result beat")

endmodule

bind sorted_list_queue_top slq_checker u_slq_checker (.*);

// ----- dv/tb_sorted_list_queue_top.sv -----
// Testbench for sorted_list_queue_top: directed and random commands checked against a predictor.
module tb_sorted_list_queue_top;
	import slq_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 4 * DEPTH + 8;
	localparam int N_RANDOM = 1275;

	typedef struct {
		slq_cmd_t c;
		bit       drain;
	} cmd_plan_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	slq_cmd_t    cmd;
	logic        done;
	slq_result_t result;

	sorted_list_queue_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	cmd_plan_t   plan_q[$];
	slq_result_t expected_results[$];
	cmd_plan_t   cur_plan;

	logic signed [31:0] sorted_vals [DEPTH];
	int          n_held;
	int          n_issued;
	int          n_accepted;
	int          n_errors;
	int          idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic slq_result_t apply_cmd(slq_cmd_t c);
		slq_result_t        r;
		logic signed [31:0] v;
		logic signed [31:0] t;
		int                 pos;
		int                 lo;
		int                 hi;
		r.ok = 1'b1;
		r.head_value = '0;
		v = c.value;
		case (c.action)
			ACT_INSERT: begin
				if (n_held >= DEPTH) begin
					r.ok = 1'b0;
				end else begin
					pos = 0;
					while (pos < n_held && sorted_vals[pos] < v)
						pos++;
					for (int i = n_held; i > pos; i--)
						sorted_vals[i] = sorted_vals[i - 1];
					sorted_vals[pos] = v;
					n_held++;
				end
			end
			ACT_POP: begin
				if (n_held == 0) begin
					r.ok = 1'b0;
				end else begin
					r.head_value = sorted_vals[0];
					for (int i = 0; i + 1 < n_held; i++)
						sorted_vals[i] = sorted_vals[i + 1];
					n_held--;
				end
			end
			ACT_REVERSE: begin
				lo = 0;
				hi = n_held - 1;
				while (lo < hi) begin
					t = sorted_vals[lo];
					sorted_vals[lo] = sorted_vals[hi];
					sorted_vals[hi] = t;
					lo++;
					hi--;
				end
			end
			default: begin
				n_held = 0;
			end
		endcase
		return r;
	endfunction

	task automatic add_cmd(logic [1:0] act, logic signed [31:0] val, bit drain = 1'b0);
		cmd_plan_t p;
		p.c.action = act;
		p.c.value = val;
		p.drain = drain;
		plan_q.push_back(p);
	endtask

	function automatic logic signed [31:0] rand_value();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return $urandom;
		else if (sel < 7)
			return $signed($urandom_range(0, 16)) - 8;
		else if (sel == 7) begin
			case ($urandom_range(0, 3))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
		end else
			return $signed({$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)});
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && n_accepted != n_issued) begin
				// hold the beat until taken
			end else if (plan_q.size() == 0) begin
				start <= 1'b0;
			end else if (plan_q[0].drain && expected_results.size() != 0) begin
				start <= 1'b0;
			end else if (!(n_issued >= 500 && n_issued < 800) && $urandom_range(0, 99) < 20) begin
				start <= 1'b0;
			end else begin
				cur_plan = plan_q.pop_front();
				cmd <= cur_plan.c;
				start <= 1'b1;
				n_issued++;
			end
		end
	end

	// monitor and predictor
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result ok=%0b head_value=%0d",
						$time, result.ok, result.head_value);
					n_errors++;
				end else begin
					if (result.ok !== expected_results[0].ok) begin
						$display("%0t: ok mismatch expected=%0b actual=%0b",
							$time, expected_results[0].ok, result.ok);
						n_errors++;
					end
					if (result.head_value !== expected_results[0].head_value) begin
						$display("%0t: head_value mismatch expected=%0d actual=%0d",
							$time, expected_results[0].head_value, result.head_value);
						n_errors++;
					end
					void'(expected_results.pop_front());
				end
			end
			if (start && !busy) begin
				expected_results.push_back(apply_cmd(cmd));
				n_accepted++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int unsigned bias;
		int unsigned r;
		n_held = 0;
		n_issued = 0;
		n_accepted = 0;
		n_errors = 0;
		idle_cycles = 0;
		for (int i = 0; i < DEPTH; i++)
			sorted_vals[i] = '0;

		// empty store corner cases, then extreme and equal values, then filling the store
		add_cmd(ACT_POP, 32'sh7fff_ffff);
		add_cmd(ACT_REVERSE, 32'sh8000_0000);
		add_cmd(ACT_CLEAR, -32'sd1);
		add_cmd(ACT_INSERT, 32'sh7fff_ffff);
		add_cmd(ACT_INSERT, 32'sh8000_0000);
		add_cmd(ACT_INSERT, 32'sd0);
		add_cmd(ACT_INSERT, -32'sd1);
		add_cmd(ACT_INSERT, 32'sd5);
		add_cmd(ACT_INSERT, 32'sd5);
		add_cmd(ACT_REVERSE, 32'sd0);
		add_cmd(ACT_POP, 32'sd0);
		add_cmd(ACT_POP, 32'sd0);
		for (int i = 0; i < DEPTH - 4; i++)
			add_cmd(ACT_INSERT, $signed($urandom_range(0, 6)) - 3);
		// full store
		add_cmd(ACT_INSERT, 32'sh8000_0000);
		add_cmd(ACT_REVERSE, 32'sd0);
		add_cmd(ACT_CLEAR, 32'sd0);
		add_cmd(ACT_INSERT, 32'sd7);
		add_cmd(ACT_REVERSE, 32'sd0);
		add_cmd(ACT_POP, 32'sd0);
		add_cmd(ACT_POP, 32'sd0);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 100 == 0)
				bias = $urandom_range(0, 2);
			r = $urandom_range(0, 99);
			if (r < 2)
				add_cmd(ACT_CLEAR, $urandom, n == 650);
			else if (r < 10)
				add_cmd(ACT_REVERSE, $urandom, n == 650);
			else if (r < (bias == 0 ? 80 : (bias == 1 ? 30 : 55)))
				add_cmd(ACT_INSERT, rand_value(), n == 650);
			else
				add_cmd(ACT_POP, $urandom, n == 650);
		end

		@(posedge arst_n);
		while (plan_q.size() != 0 || n_accepted != n_issued)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_errors == 0 && expected_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
